// ===== design/lc3b_instruction_step_core_defines.svh =====
// Assertion macros used by the port-level checker of the LC-3b step core.
// No dependencies.
`ifndef LC3B_INSTRUCTION_STEP_CORE_DEFINES_SVH
`define LC3B_INSTRUCTION_STEP_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LC3B_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lc3b assertion failed");

// next-cycle implication, disabled in reset
`define LC3B_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lc3b assertion failed");

`endif

// ===== design/lc3b_pkg.sv =====
// Package for the LC-3b step core: opcodes, item kind and shift codes, helpers.
// No dependencies.
`default_nettype none
package lc3b_pkg;
  localparam int unsigned RegCount = 8;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LDB  = 4'd2;
  localparam logic [3:0] OP_STB  = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDW  = 4'd6;
  localparam logic [3:0] OP_STW  = 4'd7;
  localparam logic [3:0] OP_XOR  = 4'd9;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_SHF  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic KIND_LOAD = 1'b0;

  localparam logic [1:0] SHF_LEFT = 2'd0;
  localparam logic [1:0] SHF_RL   = 2'd1;

  // N/Z/P from a written value
  function automatic logic [2:0] codes_of(input logic [15:0] v);
    logic [2:0] c;
    if (v[15]) c = 3'b100;
    else if (v == 16'h0000) c = 3'b010;
    else c = 3'b001;
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== design/lc3b_if.sv =====
// Valid/ready channel interfaces for step items and results.
// No dependencies.
`default_nettype none
interface lc3b_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [14:0] load_word_addr;
  logic [15:0] load_word_data;
  modport source (output valid, kind, load_word_addr, load_word_data, input ready);
  modport sink (input valid, kind, load_word_addr, load_word_data, output ready);
endinterface

interface lc3b_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_now;
  logic [2:0]  nzp;
  logic        reg_written;
  logic [2:0]  reg_number;
  logic [15:0] reg_value;
  logic        store_done;
  logic [15:0] store_addr;
  logic [15:0] store_data;
  logic [1:0]  store_bytes;
  logic        halted;
  modport source (output valid, pc_now, nzp, reg_written, reg_number, reg_value,
                  store_done, store_addr, store_data, store_bytes, halted,
                  input ready);
  modport sink (input valid, pc_now, nzp, reg_written, reg_number, reg_value,
                store_done, store_addr, store_data, store_bytes, halted,
                output ready);
endinterface
`default_nettype wire

// ===== design/lc3b_mem.sv =====
// Main word memory: single port, registered read, clearing pass after reset.
// No package dependencies.
`default_nettype none
module lc3b_mem #(
  parameter int unsigned AW = 15
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [15:0]   wdata,
  output logic      [15:0]   rdata,
  output logic               busy
);
  logic [15:0]   mem [2**AW];
  logic [AW-1:0] clr_addr;

  // clearing sweep, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {AW{1'b1}}) busy <= 1'b0;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 16'h0000;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/lc3b_rf.sv =====
// Register file: one write port, two registered read ports, valid bits.
// Depends on lc3b_pkg.
`default_nettype none
module lc3b_rf (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        we,
  input  wire logic [2:0]  waddr,
  input  wire logic [15:0] wdata,
  input  wire logic [2:0]  raddr_a,
  input  wire logic [2:0]  raddr_b,
  output logic      [15:0] rdata_a,
  output logic      [15:0] rdata_b
);
  import lc3b_pkg::*;

  logic [15:0]         regs [RegCount];
  logic [RegCount-1:0] vld;

  // valid bits stand in for the reset value of zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) regs[waddr] <= wdata;
    rdata_a <= vld[raddr_a] ? regs[raddr_a] : 16'h0000;
    rdata_b <= vld[raddr_b] ? regs[raddr_b] : 16'h0000;
  end
endmodule
`default_nettype wire

// ===== design/lc3b_instruction_step_core.sv =====
// LC-3b step core. Load items write the word and register the result on
// transfer. Execute items: fetch, register read, execute; LDB, LDW, STB and
// TRAP add a data memory step, since the single memory port is shared. An
// execute item at PC 0 finishes at once. Next item is taken once the
// sequencer is idle and the result slot is free. Reset: PC 0, codes Z,
// registers zero; then a clearing pass zeroes memory, during which no item is taken.
`default_nettype none
module lc3b_instruction_step_core #(
  parameter int unsigned MEM_WORDS = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_pc_we,
  input  wire logic [15:0] start_pc_data,
  lc3b_in_if.sink          step_in,
  lc3b_out_if.source       step_out
);
  import lc3b_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_MEM   = 2'd3;

  logic [1:0]  state, state_next;
  logic [15:0] pc;
  logic [2:0]  cc;
  logic [15:0] ir;
  logic [15:0] addr_r;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata, mem_rdata;
  logic          mem_busy;

  logic [15:0] ir_src;
  logic [2:0]  rf_ra, rf_rb;
  logic [15:0] rf_a, rf_b;

  logic        accept;
  logic        fin, fin_wr, fin_st, fin_cc;
  logic [2:0]  fin_rnum;
  logic [15:0] fin_rval, fin_saddr, fin_sdata, fin_pc;
  logic [1:0]  fin_sbytes;

  logic [3:0]  op;
  logic [15:0] npc, opnd2, sext6, addr_b, addr_w, word_r, byte_r;
  logic [2:0]  cc_next;

  lc3b_mem #(.AW(AW)) u_mem (
    .clk(clk), .rst(rst), .we(mem_we), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata), .busy(mem_busy)
  );

  // register read addresses come from the fetched word, then from ir
  assign ir_src = (state == S_FETCH) ? mem_rdata : ir;
  assign rf_ra  = ir_src[8:6];
  assign rf_rb  = (ir_src[15:12] == OP_STB || ir_src[15:12] == OP_STW) ?
                  ir_src[11:9] : ir_src[2:0];

  lc3b_rf u_rf (
    .clk(clk), .rst(rst), .we(fin && fin_wr), .waddr(fin_rnum),
    .wdata(fin_rval), .raddr_a(rf_ra), .raddr_b(rf_rb),
    .rdata_a(rf_a), .rdata_b(rf_b)
  );

  assign step_in.ready = (state == S_IDLE) && !mem_busy &&
                         (!step_out.valid || step_out.ready);
  assign accept = step_in.valid && step_in.ready;

  // datapath helpers
  assign op     = ir[15:12];
  assign npc    = pc + 16'd2;
  assign opnd2  = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf_b;
  assign sext6  = {{10{ir[5]}}, ir[5:0]};
  assign addr_b = rf_a + sext6;
  assign addr_w = rf_a + {sext6[14:0], 1'b0};
  assign word_r = mem_rdata;
  assign byte_r = addr_r[0] ? {{8{word_r[15]}}, word_r[15:8]} :
                              {{8{word_r[7]}}, word_r[7:0]};

  // sequencer, memory port and result formation
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = pc[AW:1];
    mem_wdata  = 16'h0000;
    fin        = 1'b0;
    fin_wr     = 1'b0;
    fin_st     = 1'b0;
    fin_cc     = 1'b0;
    fin_rnum   = 3'd0;
    fin_rval   = 16'h0000;
    fin_saddr  = 16'h0000;
    fin_sdata  = 16'h0000;
    fin_sbytes = 2'd0;
    fin_pc     = pc;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (step_in.kind == KIND_LOAD) begin
            mem_we    = 1'b1;
            mem_addr  = step_in.load_word_addr[AW-1:0];
            mem_wdata = step_in.load_word_data;
            fin       = 1'b1;
          end else if (pc != 16'h0000) begin
            state_next = S_FETCH;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_FETCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        fin    = 1'b1;
        fin_pc = npc;
        state_next = S_IDLE;
        unique case (op)
          OP_ADD: begin
            fin_wr = 1'b1; fin_cc = 1'b1; fin_rnum = ir[11:9];
            fin_rval = rf_a + opnd2;
          end
          OP_AND: begin
            fin_wr = 1'b1; fin_cc = 1'b1; fin_rnum = ir[11:9];
            fin_rval = rf_a & opnd2;
          end
          OP_XOR: begin
            fin_wr = 1'b1; fin_cc = 1'b1; fin_rnum = ir[11:9];
            fin_rval = rf_a ^ opnd2;
          end
          OP_SHF: begin
            fin_wr = 1'b1; fin_cc = 1'b1; fin_rnum = ir[11:9];
            if (ir[5:4] == SHF_LEFT) fin_rval = rf_a << ir[3:0];
            else if (ir[5:4] == SHF_RL) fin_rval = rf_a >> ir[3:0];
            else fin_rval = 16'($signed(rf_a) >>> ir[3:0]);
          end
          OP_LEA: begin
            fin_wr = 1'b1; fin_rnum = ir[11:9];
            fin_rval = npc + {{6{ir[8]}}, ir[8:0], 1'b0};
          end
          OP_BR: begin
            if ((ir[11:9] & cc) != 3'b000)
              fin_pc = npc + {{6{ir[8]}}, ir[8:0], 1'b0};
          end
          OP_JMP: begin
            fin_pc = rf_a;
          end
          OP_JSR: begin
            fin_wr = 1'b1; fin_rnum = 3'd7; fin_rval = npc;
            fin_pc = ir[11] ? npc + {{4{ir[10]}}, ir[10:0], 1'b0} : rf_a;
          end
          OP_STW: begin
            mem_we     = 1'b1;
            mem_addr   = addr_w[AW:1];
            mem_wdata  = rf_b;
            fin_st     = 1'b1;
            fin_saddr  = {addr_w[15:1], 1'b0};
            fin_sdata  = rf_b;
            fin_sbytes = 2'b11;
          end
          OP_LDB, OP_STB: begin
            fin        = 1'b0;
            mem_addr   = addr_b[AW:1];
            state_next = S_MEM;
          end
          OP_LDW: begin
            fin        = 1'b0;
            mem_addr   = addr_w[AW:1];
            state_next = S_MEM;
          end
          OP_TRAP: begin
            fin        = 1'b0;
            mem_addr   = AW'(ir[7:0]);
            state_next = S_MEM;
          end
          default: begin
          end
        endcase
      end
      S_MEM: begin
        fin        = 1'b1;
        fin_pc     = npc;
        state_next = S_IDLE;
        mem_addr   = addr_r[AW:1];
        unique case (op)
          OP_LDB: begin
            fin_wr = 1'b1; fin_cc = 1'b1; fin_rnum = ir[11:9]; fin_rval = byte_r;
          end
          OP_LDW: begin
            fin_wr = 1'b1; fin_cc = 1'b1; fin_rnum = ir[11:9]; fin_rval = word_r;
          end
          OP_STB: begin
            mem_we     = 1'b1;
            mem_wdata  = addr_r[0] ? {rf_b[7:0], word_r[7:0]} :
                                     {word_r[15:8], rf_b[7:0]};
            fin_st     = 1'b1;
            fin_saddr  = addr_r;
            fin_sdata  = {8'h00, rf_b[7:0]};
            fin_sbytes = addr_r[0] ? 2'b10 : 2'b01;
          end
          default: begin
            // trap: vector word is the new PC
            fin_wr = 1'b1; fin_rnum = 3'd7; fin_rval = npc; fin_pc = word_r;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign cc_next = fin_cc ? codes_of(fin_rval) : cc;

  // architectural state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= 16'h0000;
      cc    <= 3'b010;
    end else begin
      state <= state_next;
      if (start_pc_we) pc <= start_pc_data;
      else if (fin) pc <= fin_pc;
      if (fin) cc <= cc_next;
    end
  end

  // instruction and data address holding
  always_ff @(posedge clk) begin
    if (state == S_FETCH) ir <= mem_rdata;
    if (state == S_EXEC) addr_r <= (op == OP_LDW) ? addr_w : addr_b;
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      step_out.valid <= 1'b0;
    end else if (fin) begin
      step_out.valid <= 1'b1;
    end else if (step_out.ready) begin
      step_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      step_out.pc_now      <= fin_pc;
      step_out.nzp         <= cc_next;
      step_out.reg_written <= fin_wr;
      step_out.reg_number  <= fin_rnum;
      step_out.reg_value   <= fin_rval;
      step_out.store_done  <= fin_st;
      step_out.store_addr  <= fin_saddr;
      step_out.store_data  <= fin_sdata;
      step_out.store_bytes <= fin_sbytes;
      step_out.halted      <= (fin_pc == 16'h0000);
    end
  end
endmodule
`default_nettype wire

// ===== design/lc3b_chk.sv =====
// Port-level checker for the LC-3b step core, bound to the top level.
// Depends on lc3b_instruction_step_core_defines.svh.
`default_nettype none
`include "lc3b_instruction_step_core_defines.svh"
module lc3b_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] pc_now,
  input wire logic        halted,
  input wire logic        reg_written,
  input wire logic [2:0]  reg_number,
  input wire logic [15:0] reg_value,
  input wire logic        store_done,
  input wire logic [1:0]  store_bytes
);
  `LC3B_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pc_now))
  `LC3B_ASSERT_NOW(a_halt_pc, clk, rst, out_valid, halted == (pc_now == 16'h0000))
  `LC3B_ASSERT_NOW(a_no_reg, clk, rst, out_valid && !reg_written, reg_number == 3'd0 && reg_value == 16'h0000)
  `LC3B_ASSERT_NOW(a_store_be, clk, rst, out_valid, store_done == (store_bytes != 2'b00))
endmodule

bind lc3b_instruction_step_core lc3b_chk u_chk (
  .clk(clk), .rst(rst), .out_valid(step_out.valid), .out_ready(step_out.ready),
  .pc_now(step_out.pc_now), .halted(step_out.halted),
  .reg_written(step_out.reg_written), .reg_number(step_out.reg_number),
  .reg_value(step_out.reg_value), .store_done(step_out.store_done),
  .store_bytes(step_out.store_bytes)
);
`default_nettype wire
